@@ design/indexed_sequence_list_macros.svh @@
// Assertion macros used by the top level of the indexed sequence list RTL.
`ifndef INDEXED_SEQUENCE_LIST_MACROS_SVH
`define INDEXED_SEQUENCE_LIST_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ISL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define ISL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

@@ design/isl_pkg.sv @@
// Package: types, widths and codes of the indexed sequence list.
`default_nettype none

package isl_pkg;

  // Storage geometry
  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // Fixed field widths of the channels
  localparam int OPCODE_W  = 3;
  localparam int POS_W     = 8;
  localparam int IN_VAL_W  = 32;
  localparam int STATUS_W  = 2;
  localparam int OUT_VAL_W = 32;
  localparam int OUT_IDX_W = 5;
  localparam int OUT_CNT_W = 6;

  // Width for comparing a position against the count
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W + 1 : CNT_W + 1;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_PREPEND   = 3'd1,
    OP_INSERT_AT = 3'd2,
    OP_REM_LAST  = 3'd3,
    OP_REM_FIRST = 3'd4,
    OP_REM_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_ROT
  } cell_mode_e;

  // Broadcast control for the row of cells
  typedef struct packed {
    cell_mode_e       mode;
    logic [IDX_W-1:0] pos;
  } cell_ctl_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_DUMP
  } fsm_e;

endpackage

`default_nettype wire

@@ design/isl_in_if.sv @@
// Interface: command word channel of the indexed sequence list.
`default_nettype none

interface isl_in_if;
  import isl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic [POS_W-1:0]           position;
  logic signed [IN_VAL_W-1:0] value;

  modport source (output valid, output opcode, output position, output value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value,
                  output ready);
endinterface

`default_nettype wire

@@ design/isl_out_if.sv @@
// Interface: result word channel of the indexed sequence list.
`default_nettype none

interface isl_out_if;
  import isl_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [STATUS_W-1:0]         status;
  logic signed [OUT_VAL_W-1:0] entry_value;
  logic [OUT_IDX_W-1:0]        entry_index;
  logic [OUT_CNT_W-1:0]        entry_count;
  logic                        last;

  modport source (output valid, output status, output entry_value,
                  output entry_index, output entry_count, output last,
                  input ready);
  modport sink   (input valid, input status, input entry_value,
                  input entry_index, input entry_count, input last,
                  output ready);
endinterface

`default_nettype wire

@@ design/indexed_sequence_list.sv @@
// Top level of the indexed sequence list: command decode, dump sequencer, output word.
`default_nettype none

// Ordered list of up to 32 signed entries held in a row of cells. Append,
// prepend, insert-at and the three removes shift the cells (unless refused as
// full or empty) and return one result word. A dump walks the list by rotating
// the occupied cells once per word through the first cell, one word per entry
// (a single empty-status word for an empty list), and no command is taken
// until the last dump word has been loaded. A new command is taken in the
// cycle the pending result word leaves. No clearing pass after reset.
module indexed_sequence_list (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  isl_in_if.sink     in_i,
  isl_out_if.source  out_o
);
  import isl_pkg::*;

  `include "indexed_sequence_list_macros.svh"

  fsm_e                  state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      k_q, k_d;
  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [OUT_VAL_W-1:0]  value_q, value_d;
  logic [OUT_IDX_W-1:0]  index_q, index_d;
  logic                  last_q, last_d;
  logic [OUT_CNT_W-1:0]  ocount_q;
  logic                  load;
  logic                  out_free;
  logic                  acc;
  logic                  dump_last;
  logic                  pos_past_end;
  logic                  pos_past_last;
  cell_ctl_t             ctl;
  value_t                head;
  value_t                new_word;

  // Handshake
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == FSM_IDLE) && out_free;
  assign acc = in_i.valid && in_i.ready;

  // Clamp helpers
  assign pos_past_end  = CMP_W'(in_i.position) > CMP_W'(count_q);
  assign pos_past_last = CMP_W'(in_i.position) >= CMP_W'(count_q);
  assign dump_last     = CNT_W'(k_q) == count_q - 1'b1;
  assign new_word      = VALUE_WIDTH'(in_i.value);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (acc && (op_e'(in_i.opcode) == OP_DUMP) && (count_q != '0)) begin
          state_d = FSM_DUMP;
        end
      end
      FSM_DUMP: begin
        if (out_free && dump_last) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // Cell commands, count update and result word
  always_comb begin
    ctl.mode = CELL_HOLD;
    ctl.pos  = '0;
    count_d  = count_q;
    k_d      = k_q;
    load     = 1'b0;
    status_d = ST_OK;
    value_d  = '0;
    index_d  = '0;
    last_d   = 1'b1;
    unique case (state_q)
      FSM_IDLE: begin
        if (acc) begin
          load = 1'b1;
          unique case (op_e'(in_i.opcode))
            OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                ctl.mode = CELL_INS;
                if (op_e'(in_i.opcode) == OP_APPEND) begin
                  ctl.pos = IDX_W'(count_q);
                end else if (op_e'(in_i.opcode) == OP_PREPEND) begin
                  ctl.pos = '0;
                end else begin
                  ctl.pos = pos_past_end ? IDX_W'(count_q) : IDX_W'(in_i.position);
                end
                count_d = count_q + 1'b1;
              end
            end
            OP_REM_LAST, OP_REM_FIRST, OP_REM_AT: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                ctl.mode = CELL_REM;
                if (op_e'(in_i.opcode) == OP_REM_LAST) begin
                  ctl.pos = IDX_W'(count_q - 1'b1);
                end else if (op_e'(in_i.opcode) == OP_REM_FIRST) begin
                  ctl.pos = '0;
                end else begin
                  ctl.pos = pos_past_last ? IDX_W'(count_q - 1'b1)
                                          : IDX_W'(in_i.position);
                end
                count_d = count_q - 1'b1;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                // words come from the dump sequencer
                load = 1'b0;
                k_d  = '0;
              end
            end
            default: status_d = ST_OK;
          endcase
        end
      end
      FSM_DUMP: begin
        if (out_free) begin
          load     = 1'b1;
          value_d  = OUT_VAL_W'(signed'(head));
          index_d  = OUT_IDX_W'(k_q);
          last_d   = dump_last;
          ctl.mode = CELL_ROT;
          ctl.pos  = IDX_W'(count_q - 1'b1);
          k_d      = k_q + 1'b1;
        end
      end
      default: load = 1'b0;
    endcase
  end

  isl_chain u_chain (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .new_i  (new_word),
    .head_o (head)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q <= status_d;
      value_q  <= value_d;
      index_q  <= index_d;
      last_q   <= last_d;
      ocount_q <= OUT_CNT_W'(count_d);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = status_q;
  assign out_o.entry_value = value_q;
  assign out_o.entry_index = index_q;
  assign out_o.entry_count = ocount_q;
  assign out_o.last        = last_q;

  // Checks
  `ISL_ASSERT(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `ISL_ASSERT(a_dump_blocks, (state_q == FSM_DUMP) |-> !in_i.ready,
    "command taken during dump")
  `ISL_ASSERT(a_dump_nonempty, (state_q == FSM_DUMP) |-> (count_q != '0),
    "dump of empty list")
  `ISL_ASSERT_NEXT(a_full_holds,
    acc && (count_q == CNT_W'(CAPACITY)) && (in_i.opcode == OP_APPEND),
    $stable(count_q), "append to full list changed count")
  `ISL_ASSERT_NEXT(a_dump_done, (state_q == FSM_DUMP) && out_free && dump_last,
    (state_q == FSM_IDLE) && out_valid_q && out_o.last, "dump did not end on last word")
endmodule

`default_nettype wire

@@ design/isl_cell.sv @@
// One storage cell of the list: holds one entry, loads from a neighbor, the head or the new word.
`default_nettype none

module isl_cell (
  input  wire logic                     clk_i,
  input  wire isl_pkg::cell_ctl_t       ctl_i,
  input  wire logic [isl_pkg::IDX_W-1:0] cell_idx_i,
  input  wire isl_pkg::value_t          left_i,
  input  wire isl_pkg::value_t          right_i,
  input  wire isl_pkg::value_t          head_i,
  input  wire isl_pkg::value_t          new_i,
  output isl_pkg::value_t               data_o
);
  import isl_pkg::*;

  value_t data_q, data_d;

  // Select the next content from the broadcast command
  always_comb begin
    data_d = data_q;
    case (ctl_i.mode)
      CELL_INS: begin
        // cells after the slot move one up, the slot takes the new word
        if (cell_idx_i > ctl_i.pos) begin
          data_d = left_i;
        end else if (cell_idx_i == ctl_i.pos) begin
          data_d = new_i;
        end
      end
      CELL_REM: begin
        // the removed slot and those after it close the gap
        if (cell_idx_i >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      CELL_ROT: begin
        // rotate the occupied part by one; pos marks the last entry
        if (cell_idx_i < ctl_i.pos) begin
          data_d = right_i;
        end else if (cell_idx_i == ctl_i.pos) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
endmodule

`default_nettype wire

@@ design/isl_chain.sv @@
// Row of list cells; entry 0 sits in the first cell.
`default_nettype none

module isl_chain (
  input  wire logic               clk_i,
  input  wire isl_pkg::cell_ctl_t ctl_i,
  input  wire isl_pkg::value_t    new_i,
  output isl_pkg::value_t         head_o
);
  import isl_pkg::*;

  value_t cell_q [CAPACITY];

  // Each cell sees its two neighbors, the head and the incoming word
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left, right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_q[i+1];
    end

    isl_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .cell_idx_i (IDX_W'(i)),
      .left_i     (left),
      .right_i    (right),
      .head_i     (cell_q[0]),
      .new_i      (new_i),
      .data_o     (cell_q[i])
    );
  end

  assign head_o = cell_q[0];
endmodule

`default_nettype wire

@@ test/indexed_sequence_list_tb.sv @@
// Testbench for the indexed sequence list: directed table, random commands, scoreboard.
`timescale 1ns / 1ps

module indexed_sequence_list_tb;
  import isl_pkg::*;

  // Opcode seven is outside the enum; the block answers it with a plain status word
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  localparam int RANDOM_ITEMS  = 104;
  localparam int PHASE_ITEMS   = 13;
  localparam int LONG_HOLD     = 64;
  localparam int DRAIN_CYCLES  = 40;
  localparam int MAX_REPORTS   = 10;

  typedef enum logic [1:0] {
    TREND_GROW,
    TREND_MIXED,
    TREND_SHRINK
  } fill_trend_e;

  // One result word as the block should return it
  typedef struct packed {
    logic [STATUS_W-1:0]         status;
    logic signed [OUT_VAL_W-1:0] value;
    logic [OUT_IDX_W-1:0]        index;
    logic [OUT_CNT_W-1:0]        count;
    logic                        last;
  } result_word_t;

  // Directed row: command, repeat count, optional typed-in single result
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    logic [IN_VAL_W-1:0] val;
    logic [5:0]          reps;
    logic                typed;
    logic [STATUS_W-1:0] t_status;
    logic [OUT_CNT_W-1:0] t_count;
  } stim_row_t;

  localparam int N_ROWS = 28;
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    // removes and dump on the empty list
    '{OP_REM_FIRST, 8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_EMPTY, 6'd0},
    '{OP_REM_LAST,  8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_EMPTY, 6'd0},
    '{OP_REM_AT,    8'd255, 32'h0000_0000, 6'd1,  1'b1, ST_EMPTY, 6'd0},
    '{OP_DUMP,      8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_EMPTY, 6'd0},
    // value extremes, insert in the middle and beyond the end
    '{OP_APPEND,    8'd0,   32'h7FFF_FFFF, 6'd1,  1'b1, ST_OK,    6'd1},
    '{OP_PREPEND,   8'd0,   32'h8000_0000, 6'd1,  1'b1, ST_OK,    6'd2},
    '{OP_INSERT_AT, 8'd1,   32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd3},
    '{OP_INSERT_AT, 8'd255, 32'hFFFF_FFFF, 6'd1,  1'b1, ST_OK,    6'd4},
    '{OP_DUMP,      8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK,    6'd0},
    // remove beyond the end takes the last entry
    '{OP_REM_AT,    8'd255, 32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd3},
    '{OP_REM_AT,    8'd1,   32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd2},
    '{OP_UNUSED,    8'd170, 32'h5555_AAAA, 6'd1,  1'b1, ST_OK,    6'd2},
    '{OP_DUMP,      8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK,    6'd0},
    '{OP_REM_LAST,  8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd1},
    '{OP_REM_FIRST, 8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd0},
    '{OP_DUMP,      8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_EMPTY, 6'd0},
    // fill to capacity, then inserts are refused
    '{OP_INSERT_AT, 8'd0,   32'h1234_5678, 6'd1,  1'b1, ST_OK,    6'd1},
    '{OP_APPEND,    8'd0,   32'hA5A5_0000, 6'd31, 1'b0, ST_OK,    6'd0},
    '{OP_INSERT_AT, 8'd16,  32'h0BAD_F00D, 6'd1,  1'b1, ST_FULL,  6'd32},
    '{OP_APPEND,    8'd0,   32'h0BAD_F00D, 6'd1,  1'b1, ST_FULL,  6'd32},
    '{OP_PREPEND,   8'd0,   32'h0BAD_F00D, 6'd1,  1'b1, ST_FULL,  6'd32},
    '{OP_DUMP,      8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK,    6'd0},
    '{OP_REM_AT,    8'd0,   32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd31},
    '{OP_REM_AT,    8'd31,  32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd30},
    '{OP_INSERT_AT, 8'd30,  32'h8000_0000, 6'd1,  1'b1, ST_OK,    6'd31},
    '{OP_DUMP,      8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK,    6'd0},
    '{OP_REM_AT,    8'd15,  32'h0000_0000, 6'd1,  1'b1, ST_OK,    6'd30},
    '{OP_DUMP,      8'd0,   32'h0000_0000, 6'd1,  1'b0, ST_OK,    6'd0}
  };

  // Fill trend of each block of random commands
  localparam fill_trend_e TREND_PLAN [8] = '{
    TREND_GROW, TREND_GROW, TREND_GROW, TREND_SHRINK,
    TREND_SHRINK, TREND_MIXED, TREND_GROW, TREND_MIXED
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  isl_in_if  cmd_ch ();
  isl_out_if res_ch ();

  indexed_sequence_list i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  always #5 clk_i = ~clk_i;

  // Shadow list and the words it says should come out
  logic signed [IN_VAL_W-1:0] list_shadow [$];
  result_word_t               expected_words [$];

  bit idling_on     = 1'b1;
  bit long_hold_req = 1'b0;
  int error_count   = 0;
  int words_checked = 0;
  int commands_done = 0;
  int dumps_done    = 0;
  int full_refusals = 0;
  int empty_refusals = 0;
  int peak_fill     = 0;

  // Apply one command to the shadow list and queue the words it causes
  task automatic apply_command(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                               input logic signed [IN_VAL_W-1:0] val);
    result_word_t w;
    int n;
    int p;
    n = list_shadow.size();
    w.status = ST_OK;
    w.value  = '0;
    w.index  = '0;
    w.count  = '0;
    w.last   = 1'b1;
    commands_done++;
    case (op)
      OP_APPEND, OP_PREPEND, OP_INSERT_AT: begin
        if (n >= CAPACITY) begin
          w.status = ST_FULL;
          full_refusals++;
        end else begin
          if (op == OP_APPEND) p = n;
          else if (op == OP_PREPEND) p = 0;
          else p = (int'(pos) > n) ? n : int'(pos);
          list_shadow.insert(p, val);
        end
      end
      OP_REM_LAST, OP_REM_FIRST, OP_REM_AT: begin
        if (n == 0) begin
          w.status = ST_EMPTY;
          empty_refusals++;
        end else begin
          if (op == OP_REM_LAST) p = n - 1;
          else if (op == OP_REM_FIRST) p = 0;
          else p = (int'(pos) > n - 1) ? n - 1 : int'(pos);
          list_shadow.delete(p);
        end
      end
      OP_DUMP: begin
        dumps_done++;
        if (n == 0) begin
          w.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            w.value = list_shadow[i];
            w.index = i[OUT_IDX_W-1:0];
            w.count = n[OUT_CNT_W-1:0];
            w.last  = (i == n - 1);
            expected_words.push_back(w);
          end
          return;
        end
      end
      default: ;
    endcase
    w.count = OUT_CNT_W'(list_shadow.size());
    if (list_shadow.size() > peak_fill) peak_fill = list_shadow.size();
    expected_words.push_back(w);
  endtask

  // Offer one command word; entered and left just after a falling edge
  task automatic send_command(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic [IN_VAL_W-1:0] val, input logic typed,
                              input logic [STATUS_W-1:0] t_status,
                              input logic [OUT_CNT_W-1:0] t_count);
    result_word_t want;
    int gap;
    gap = (idling_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.opcode   <= op;
    cmd_ch.position <= pos;
    cmd_ch.value    <= val;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    apply_command(op, pos, val);
    // a typed-in word stands in for the single predicted one
    if (typed) begin
      want.status = t_status;
      want.value  = '0;
      want.index  = '0;
      want.count  = t_count;
      want.last   = 1'b1;
      void'(expected_words.pop_back());
      expected_words.push_back(want);
    end
    @(negedge clk_i);
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin : result_sink
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        for (int n = 1; n < LONG_HOLD; n++) @(negedge clk_i);
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Scoreboard: every accepted result word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_word_t want;
    if (rst_ni === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected word status %0d value %0d index %0d count %0d last %0d",
                   $realtime, res_ch.status, res_ch.entry_value, res_ch.entry_index,
                   res_ch.entry_count, res_ch.last);
      end else begin
        want = expected_words.pop_front();
        if (res_ch.status !== want.status || res_ch.entry_value !== want.value ||
            res_ch.entry_index !== want.index || res_ch.entry_count !== want.count ||
            res_ch.last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: mismatch exp status %0d value %0d index %0d count %0d last %0d",
                     $realtime, want.status, want.value, want.index, want.count, want.last);
            $display("%0t:          got status %0d value %0d index %0d count %0d last %0d",
                     $realtime, res_ch.status, res_ch.entry_value, res_ch.entry_index,
                     res_ch.entry_count, res_ch.last);
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random commands, drain
  initial begin : stimulus
    fill_trend_e trend;
    logic [OPCODE_W-1:0] op;
    logic [POS_W-1:0]    pos;
    logic [IN_VAL_W-1:0] val;
    int ins_pct;
    int r;
    int n;

    rst_ni          = 1'b0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.opcode   = OP_APPEND;
    cmd_ch.position = '0;
    cmd_ch.value    = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table
    for (int k = 0; k < N_ROWS; k++) begin
      for (int rep = 0; rep < DIRECTED[k].reps; rep++)
        send_command(DIRECTED[k].op, DIRECTED[k].pos, DIRECTED[k].val + rep,
                     DIRECTED[k].typed, DIRECTED[k].t_status, DIRECTED[k].t_count);
    end

    // Random commands, fill level steered block by block
    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      trend = TREND_PLAN[item / PHASE_ITEMS];
      idling_on = !((item / PHASE_ITEMS) == 2 || (item / PHASE_ITEMS) == 7);
      if (item == 50) long_hold_req = 1'b1;
      if (item == 100) begin
        // sender waits out every outstanding word
        cmd_ch.valid <= 1'b0;
        do @(negedge clk_i); while (expected_words.size() != 0);
      end
      case (trend)
        TREND_GROW:   ins_pct = 85;
        TREND_SHRINK: ins_pct = 7;
        default:      ins_pct = 46;
      endcase
      n = list_shadow.size();
      r = $urandom_range(0, 99);
      if (r < 8) begin
        op = OP_DUMP;
      end else if (r < 8 + ins_pct) begin
        case ($urandom_range(0, 2))
          0:       op = OP_APPEND;
          1:       op = OP_PREPEND;
          default: op = OP_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_REM_LAST;
          1:       op = OP_REM_FIRST;
          default: op = OP_REM_AT;
        endcase
      end
      pos = ($urandom_range(0, 9) < 7) ? POS_W'($urandom_range(0, n + 1))
                                        : POS_W'($urandom_range(0, 255));
      case ($urandom_range(0, 19))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = 32'h0000_0000;
        3:       val = 32'hFFFF_FFFF;
        default: val = $urandom;
      endcase
      send_command(op, pos, val, 1'b0, ST_OK, '0);
    end

    // Drain
    cmd_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (expected_words.size() != 0) begin
      error_count++;
      $display("%0d expected words never arrived", expected_words.size());
    end
    $display("Covered %0d commands and %0d result words, %0d dumps, peak fill %0d of %0d.",
             commands_done, words_checked, dumps_done, peak_fill, CAPACITY);
    $display("Refused: %0d inserts into a full list, %0d removes from an empty one; %0d errors.",
             full_refusals, empty_refusals, error_count);
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d words still expected", expected_words.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/isl_pkg.sv
design/isl_in_if.sv
design/isl_out_if.sv
design/isl_cell.sv
design/isl_chain.sv
design/indexed_sequence_list.sv
test/indexed_sequence_list_tb.sv
